// File: rtl/jts_pkg.sv
// Shared types and constants for the JSON token scanner.
package jts_pkg;

    // Default width of the byte position counters.
    localparam int OFFSET_BITS_DEF = 16;
    // Default depth of the record queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Token kind codes carried in each record.
    localparam logic [2:0] K_PUNCT  = 3'd0;
    localparam logic [2:0] K_STRING = 3'd1;
    localparam logic [2:0] K_NUMBER = 3'd2;
    localparam logic [2:0] K_WORD   = 3'd3;
    localparam logic [2:0] K_ERROR  = 3'd4;

    // One input byte transfer.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in;

    // One result record transfer.
    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  punct_char;
        logic [15:0] token_offset;
        logic [15:0] token_length;
        logic        run_end;
    } t_rec;

    // Everything one byte produces, held as one queue entry.
    typedef struct packed {
        logic two;
        t_rec rec0;
        t_rec rec1;
    } t_entry;

endpackage

// File: rtl/jts_queue.sv
// Small register-based first-in first-out queue of fixed-width entries.
module jts_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: rtl/jts_front.sv
// Front end of the token scanner: byte classification, scan state and record building.
module jts_front
    import jts_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_in    i_in_data,
    input  logic   i_q_full,
    output logic   o_q_push,
    output t_entry o_q_entry
);

    typedef enum logic [12:0] {
        M_IDLE    = 13'b0000000000001,
        M_STR     = 13'b0000000000010,
        M_ESC     = 13'b0000000000100,
        M_HEX     = 13'b0000000001000,
        M_MINUS   = 13'b0000000010000,
        M_INT     = 13'b0000000100000,
        M_DOT     = 13'b0000001000000,
        M_FRAC    = 13'b0000010000000,
        M_EXPMARK = 13'b0000100000000,
        M_ESIGN   = 13'b0001000000000,
        M_EXP     = 13'b0010000000000,
        M_WORD    = 13'b0100000000000,
        M_DISCARD = 13'b1000000000000
    } t_mode;

    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_LF      = 8'h0A;
    localparam logic [7:0] C_CR      = 8'h0D;
    localparam logic [7:0] C_TAB     = 8'h09;
    localparam logic [7:0] C_QUOTE   = 8'h22;
    localparam logic [7:0] C_BSLASH  = 8'h5C;
    localparam logic [7:0] C_SLASH   = 8'h2F;
    localparam logic [7:0] C_PLUS    = 8'h2B;
    localparam logic [7:0] C_MINUS   = 8'h2D;
    localparam logic [7:0] C_DOT     = 8'h2E;
    localparam logic [7:0] C_COMMA   = 8'h2C;
    localparam logic [7:0] C_COLON   = 8'h3A;
    localparam logic [7:0] C_LBRACE  = 8'h7B;
    localparam logic [7:0] C_RBRACE  = 8'h7D;
    localparam logic [7:0] C_LBRACK  = 8'h5B;
    localparam logic [7:0] C_RBRACK  = 8'h5D;
    localparam logic [7:0] C_LOW_B   = 8'h62;
    localparam logic [7:0] C_LOW_F   = 8'h66;
    localparam logic [7:0] C_LOW_N   = 8'h6E;
    localparam logic [7:0] C_LOW_R   = 8'h72;
    localparam logic [7:0] C_LOW_T   = 8'h74;
    localparam logic [7:0] C_LOW_U   = 8'h75;
    localparam logic [7:0] C_CASE_MASK = 8'hDF;
    localparam logic [7:0] C_UP_E    = 8'h45;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    t_mode                r_mode, n_mode;
    logic [2:0]           r_hex, n_hex;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_start, n_start;

    // Scan results before the end-of-text step.
    t_mode                  s_mode;
    logic [OFFSET_BITS-1:0] s_start;
    logic                   st_taken;

    logic [7:0] ch;
    logic       fin, accept;
    logic       is_space, is_digit, is_hex, is_exp, is_punct;
    logic       st_open;
    t_mode      st_mode;
    logic [OFFSET_BITS:0] len_incl, len_excl;

    logic       a_v, b_v, c_v;
    logic [2:0] a_kind, c_kind;
    logic [OFFSET_BITS:0] a_len, c_len;
    t_rec       rec_a, rec_b, rec_c;

    function automatic logic [15:0] sat16(input logic [32:0] v);
        return (v > 33'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic t_rec make_rec(input logic [2:0] kind, input logic [7:0] pc,
                                      input logic [OFFSET_BITS-1:0] off,
                                      input logic [OFFSET_BITS:0] len);
        t_rec r;
        r.token_kind   = kind;
        r.punct_char   = pc;
        r.token_offset = sat16(33'(off));
        r.token_length = sat16(33'(len));
        r.run_end      = 1'b0;
        return r;
    endfunction

    assign ch  = i_in_data.text_byte;
    assign fin = i_in_data.final_byte;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // Byte classes.
    always_comb begin
        is_space = (ch == C_SPACE) || (ch == C_LF) || (ch == C_CR) || (ch == C_TAB);
        is_digit = (ch >= 8'h30) && (ch <= 8'h39);
        is_hex   = is_digit || ((ch >= 8'h41) && (ch <= 8'h46))
                   || ((ch >= 8'h61) && (ch <= 8'h66));
        is_exp   = ((ch & C_CASE_MASK) == C_UP_E);
        is_punct = (ch == C_LBRACE) || (ch == C_RBRACE) || (ch == C_LBRACK)
                   || (ch == C_RBRACK) || (ch == C_COMMA) || (ch == C_COLON);
        st_open  = !is_space && !is_punct;
        if (ch == C_QUOTE) begin
            st_mode = M_STR;
        end else if (ch == C_MINUS) begin
            st_mode = M_MINUS;
        end else if (is_digit) begin
            st_mode = M_INT;
        end else begin
            st_mode = M_WORD;
        end
    end

    assign len_incl = ({1'b0, r_pos} + (OFFSET_BITS + 1)'(1)) - {1'b0, r_start};
    assign len_excl = {1'b0, r_pos} - {1'b0, r_start};

    // Per-byte scan step.
    always_comb begin
        s_mode   = r_mode;
        s_start  = r_start;
        st_taken = 1'b0;
        n_hex    = r_hex;
        a_v      = 1'b0;
        a_kind   = K_PUNCT;
        a_len    = len_excl;
        b_v      = 1'b0;
        rec_a    = '0;
        rec_b    = make_rec(K_PUNCT, ch, r_pos, (OFFSET_BITS + 1)'(1));

        unique case (r_mode)
            M_IDLE: begin
                if (is_punct) begin
                    a_v    = 1'b1;
                    a_kind = K_PUNCT;
                end else if (st_open) begin
                    s_mode   = st_mode;
                    s_start  = r_pos;
                    st_taken = 1'b1;
                end
            end
            M_STR: begin
                if (ch == C_BSLASH) begin
                    s_mode = M_ESC;
                end else if (ch == C_QUOTE) begin
                    a_v    = 1'b1;
                    a_kind = K_STRING;
                    a_len  = len_incl;
                    s_mode = M_IDLE;
                end
            end
            M_ESC: begin
                if (ch == C_LOW_U) begin
                    n_hex  = 3'd4;
                    s_mode = M_HEX;
                end else if ((ch == C_QUOTE) || (ch == C_BSLASH) || (ch == C_SLASH)
                             || (ch == C_LOW_B) || (ch == C_LOW_F) || (ch == C_LOW_N)
                             || (ch == C_LOW_R) || (ch == C_LOW_T)) begin
                    s_mode = M_STR;
                end else begin
                    a_v    = 1'b1;
                    a_kind = K_ERROR;
                    a_len  = len_incl;
                    s_mode = M_DISCARD;
                end
            end
            M_HEX: begin
                if (!is_hex) begin
                    a_v    = 1'b1;
                    a_kind = K_ERROR;
                    a_len  = len_incl;
                    s_mode = M_DISCARD;
                end else begin
                    n_hex = r_hex - 3'd1;
                    if (r_hex == 3'd1) begin
                        s_mode = M_STR;
                    end
                end
            end
            M_MINUS: begin
                if (is_digit) begin
                    s_mode = M_INT;
                end else begin
                    a_v    = 1'b1;
                    a_kind = K_ERROR;
                    a_len  = len_incl;
                    s_mode = M_DISCARD;
                end
            end
            M_INT, M_DOT, M_FRAC, M_EXPMARK, M_ESIGN, M_EXP: begin
                if (is_digit) begin
                    if ((r_mode == M_DOT) || (r_mode == M_FRAC)) begin
                        s_mode = M_FRAC;
                    end else if (r_mode != M_INT) begin
                        s_mode = M_EXP;
                    end
                end else if ((r_mode == M_INT) && (ch == C_DOT)) begin
                    s_mode = M_DOT;
                end else if (((r_mode == M_INT) || (r_mode == M_DOT) || (r_mode == M_FRAC))
                             && is_exp) begin
                    s_mode = M_EXPMARK;
                end else if ((r_mode == M_EXPMARK) && ((ch == C_PLUS) || (ch == C_MINUS))) begin
                    s_mode = M_ESIGN;
                end else begin
                    // The number ends here; this byte, unless it is white space, opens the next token.
                    a_v    = 1'b1;
                    a_kind = K_NUMBER;
                    s_mode = M_IDLE;
                    if (is_punct) begin
                        b_v = 1'b1;
                    end else if (st_open) begin
                        s_mode   = st_mode;
                        s_start  = r_pos;
                        st_taken = 1'b1;
                    end
                end
            end
            M_WORD: begin
                if (is_space) begin
                    a_v    = 1'b1;
                    a_kind = K_WORD;
                    s_mode = M_IDLE;
                end
            end
            M_DISCARD: begin
            end
            default: begin
            end
        endcase

        // The last byte of a text clears the unicode digit count with the rest of the state.
        if (fin) begin
            n_hex = 3'd0;
        end

        if (a_kind == K_PUNCT) begin
            rec_a = make_rec(K_PUNCT, ch, r_pos, (OFFSET_BITS + 1)'(1));
        end else begin
            rec_a = make_rec(a_kind, 8'h00, r_start, a_len);
        end
    end

    // End of text: close or flag whatever token is still open.
    always_comb begin
        c_v    = 1'b0;
        c_kind = K_ERROR;
        c_len  = st_taken ? (OFFSET_BITS + 1)'(1) : len_incl;
        unique case (s_mode)
            M_INT, M_FRAC, M_EXP: begin
                c_v    = fin;
                c_kind = K_NUMBER;
            end
            M_WORD: begin
                c_v    = fin;
                c_kind = K_WORD;
            end
            M_STR, M_ESC, M_HEX, M_MINUS, M_DOT, M_EXPMARK, M_ESIGN: begin
                c_v    = fin;
                c_kind = K_ERROR;
            end
            M_IDLE, M_DISCARD: begin
                c_v = 1'b0;
            end
            default: begin
                c_v = 1'b0;
            end
        endcase
        rec_c = make_rec(c_kind, 8'h00, s_start, c_len);
    end

    // Next state.
    always_comb begin
        n_mode  = s_mode;
        n_start = s_start;
        n_pos   = (r_pos == POS_MAX) ? r_pos : r_pos + OFFSET_BITS'(1);
        if (fin) begin
            n_mode  = M_IDLE;
            n_start = '0;
            n_pos   = '0;
        end
    end

    // Queue entry: up to two records in transfer order.
    always_comb begin
        o_q_entry.two  = a_v && (b_v || c_v);
        o_q_entry.rec0 = a_v ? rec_a : rec_c;
        o_q_entry.rec1 = b_v ? rec_b : rec_c;
        o_q_entry.rec0.run_end = !(a_v && (b_v || c_v));
        o_q_entry.rec1.run_end = 1'b1;
        o_q_push = accept && (a_v || c_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_hex   <= 3'd0;
            r_pos   <= '0;
            r_start <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_hex   <= n_hex;
            r_pos   <= n_pos;
            r_start <= n_start;
        end
    end

endmodule

// File: rtl/jts_back.sv
// Back end of the token scanner: unpacks queue entries into single output records.
module jts_back
    import jts_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_entry i_head,
    input  logic   i_empty,
    output logic   o_pop,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_rec   o_out_data
);

    logic r_valid, n_valid;
    logic r_sel, n_sel;
    t_rec r_out, n_out;
    logic load, last;

    assign load = !r_valid || i_out_ready;
    assign last = !i_head.two || r_sel;
    assign o_pop = load && !i_empty && last;

    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        n_out   = r_out;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_out = r_sel ? i_head.rec1 : i_head.rec0;
                n_sel = !last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/json_token_scanner.sv
// Top level: a streaming JSON token scanner with a decoupled front and back end.
// A record passes the record queue and then the back end's output register to be on offer.
// Throughput: one byte per cycle while the queue has room; a byte's two records leave in
// turn: the single output register passes one record per cycle while the output is taken.
// Reset (synchronous, active low) returns the scanner to idle at offset zero, empties the
// record queue and drops any record on offer.
module json_token_scanner
    import jts_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rec o_out_data
);

    // The front end classifies each byte against the current scan state and builds the
    // records it causes, at most two, which travel together as one queue entry.
    logic   q_push, q_full, q_pop, q_empty;
    t_entry q_in, q_head;

    jts_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_entry  (q_in)
    );

    // The queue lets the front keep taking bytes while the output side is stalled, and
    // absorbs the hold-up when a byte yields two records.
    jts_queue #(
        .WIDTH($bits(t_entry)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_in),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_empty     (q_empty)
    );

    // The back end hands out one record per transfer from a registered output stage, so a
    // finished record may wait for the consumer without holding up the front end.
    jts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
